// ===== rtl/tpll_pkg.sv =====
// ----------------------------------------------------------------------------
// Tuner PLL tuning-word package
// Types, widths and the tracking-filter band table shared by the pipeline.
// ----------------------------------------------------------------------------
package tpll_pkg;

   localparam int BAND_COUNT = 21;
   localparam int XTAL_W     = 26;
   localparam int WORD_W     = 32;
   localparam int MHZ_W      = 13;
   localparam int VCO_W      = 38;
   localparam int DVD_W      = 39;
   localparam int REF_W      = 25;
   localparam int SDM_W      = 16;
   localparam int DIV_STAGES = DVD_W;

   localparam logic [12:0] MHZ_MUL     = 13'd4295;
   localparam logic [37:0] VCO_LOW_HZ  = 38'd1770000000;
   localparam logic [37:0] VCO_HIGH_HZ = 38'd3900000000;
   localparam logic [7:0]  NINT_BIAS   = 8'd13;
   localparam logic [2:0]  DIV_NONE    = 3'd5;

   localparam logic CSR_XTAL      = 1'b0;
   localparam logic CSR_IF_OFFSET = 1'b1;

   localparam logic [9:0] BAND_MHZ [BAND_COUNT] = '{
      10'd0,   10'd50,  10'd55,  10'd60,  10'd65,  10'd70,  10'd75,
      10'd80,  10'd90,  10'd100, 10'd110, 10'd120, 10'd140, 10'd180,
      10'd220, 10'd250, 10'd280, 10'd310, 10'd450, 10'd588, 10'd650};
   localparam logic BAND_OD [BAND_COUNT] = '{
      1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
      1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
   localparam logic [7:0] BAND_MUX [BAND_COUNT] = '{
      8'h02, 8'h02, 8'h02, 8'h02, 8'h02, 8'h02, 8'h02, 8'h02, 8'h02,
      8'h02, 8'h02, 8'h02, 8'h02, 8'h02, 8'h02, 8'h02, 8'h02, 8'h41,
      8'h41, 8'h40, 8'h40};
   localparam logic [7:0] BAND_CAP [BAND_COUNT] = '{
      8'hdf, 8'hbe, 8'h8b, 8'h7b, 8'h69, 8'h58, 8'h44, 8'h44, 8'h34,
      8'h34, 8'h24, 8'h24, 8'h14, 8'h13, 8'h13, 8'h11, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00};

   typedef struct packed {
      logic              valid;
      logic [4:0]        band;
      logic [2:0]        div;
      logic [VCO_W-1:0]  vco;
   } div_meta_type;

   typedef struct packed {
      logic              valid;
      logic [4:0]        band;
      logic [2:0]        div;
      logic [7:0]        fb;
      logic              fen;
   } sdm_meta_type;

   function automatic logic [4:0] band_of(input logic [MHZ_W-1:0] mhz);
      logic [4:0] cnt;
      cnt = 5'd0;
      for (int i = 1; i < BAND_COUNT; i++) begin
         if (mhz >= {3'd0, BAND_MHZ[i]}) begin
            cnt = cnt + 5'd1;
         end
      end
      return cnt;
   endfunction

endpackage

// ===== rtl/tpll_front.sv =====
// ----------------------------------------------------------------------------
// Tuner PLL front stage
// Picks the band and the output divider and forms the VCO frequency and the
// dividend for the feedback division.
// ----------------------------------------------------------------------------
module tpll_front
   import tpll_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 valid,
   input  logic [WORD_W-1:0]    lo,
   input  logic [MHZ_W-1:0]     mhz,
   input  logic [XTAL_W-1:0]    xtal,
   output div_meta_type         meta,
   output logic [DVD_W-1:0]     dividend
);

   div_meta_type         meta_ff, meta_in;
   logic [DVD_W-1:0]     dvd_ff, dvd_in;
   logic [2:0]           div_sel;
   logic [VCO_W-1:0]     cand;
   logic [VCO_W-1:0]     vco;

   always_comb begin
      div_sel = DIV_NONE;
      for (int d = 4; d >= 0; d--) begin
         cand = {6'd0, lo} << (d + 1);
         if (cand >= VCO_LOW_HZ && cand <= VCO_HIGH_HZ) begin
            div_sel = 3'(d);
         end
      end
      vco           = {6'd0, lo} << (div_sel + 3'd1);
      meta_in.valid = valid;
      meta_in.band  = band_of(mhz);
      meta_in.div   = div_sel;
      meta_in.vco   = vco;
      dvd_in        = {1'b0, vco} + {30'd0, xtal[XTAL_W-1:17]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         meta_ff.valid <= 1'b0;
      end else begin
         meta_ff.valid <= meta_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      meta_ff.band <= meta_in.band;
      meta_ff.div  <= meta_in.div;
      meta_ff.vco  <= meta_in.vco;
      dvd_ff       <= dvd_in;
   end

   assign meta     = meta_ff;
   assign dividend = dvd_ff;

endmodule

// ===== rtl/tpll_div_stage.sv =====
// ----------------------------------------------------------------------------
// Tuner PLL division stage
// One restoring step of the feedback division: one quotient bit per stage.
// ----------------------------------------------------------------------------
module tpll_div_stage
   import tpll_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic [XTAL_W-1:0]    divisor,
   input  div_meta_type         meta_i,
   input  logic [XTAL_W-1:0]    rem_i,
   input  logic [DVD_W-1:0]     dvd_i,
   input  logic [DVD_W-1:0]     quo_i,
   output div_meta_type         meta_o,
   output logic [XTAL_W-1:0]    rem_o,
   output logic [DVD_W-1:0]     dvd_o,
   output logic [DVD_W-1:0]     quo_o
);

   div_meta_type         meta_ff;
   logic [XTAL_W-1:0]    rem_ff, rem_in;
   logic [DVD_W-1:0]     dvd_ff, quo_ff, quo_in;
   logic [XTAL_W:0]      trial, diff;
   logic                 ge;

   always_comb begin
      trial  = {rem_i, dvd_i[DVD_W-1]};
      ge     = trial >= {1'b0, divisor};
      diff   = trial - {1'b0, divisor};
      rem_in = ge ? diff[XTAL_W-1:0] : trial[XTAL_W-1:0];
      quo_in = {quo_i[DVD_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         meta_ff.valid <= 1'b0;
      end else begin
         meta_ff.valid <= meta_i.valid;
      end
   end

   always_ff @(posedge clock) begin
      meta_ff.band <= meta_i.band;
      meta_ff.div  <= meta_i.div;
      meta_ff.vco  <= meta_i.vco;
      rem_ff       <= rem_in;
      dvd_ff       <= {dvd_i[DVD_W-2:0], 1'b0};
      quo_ff       <= quo_in;
   end

   assign meta_o = meta_ff;
   assign rem_o  = rem_ff;
   assign dvd_o  = dvd_ff;
   assign quo_o  = quo_ff;

endmodule

// ===== rtl/tpll_sdm_stage.sv =====
// ----------------------------------------------------------------------------
// Tuner PLL sigma-delta stage
// One step of the fraction search: tries one binary weight of the reference.
// ----------------------------------------------------------------------------
module tpll_sdm_stage
   import tpll_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic [REF_W-1:0]     step,
   input  sdm_meta_type         meta_i,
   input  logic [WORD_W-1:0]    frac_i,
   input  logic                 done_i,
   input  logic [SDM_W-1:0]     sdm_i,
   output sdm_meta_type         meta_o,
   output logic [WORD_W-1:0]    frac_o,
   output logic                 done_o,
   output logic [SDM_W-1:0]     sdm_o
);

   sdm_meta_type         meta_ff;
   logic [WORD_W-1:0]    frac_ff, frac_in, diff;
   logic                 done_ff, done_in, hit;
   logic [SDM_W-1:0]     sdm_ff;

   always_comb begin
      hit     = !done_i && (frac_i >= {7'd0, step});
      diff    = frac_i - {7'd0, step};
      frac_in = hit ? diff : frac_i;
      done_in = done_i || (hit && diff == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         meta_ff.valid <= 1'b0;
      end else begin
         meta_ff.valid <= meta_i.valid;
      end
   end

   always_ff @(posedge clock) begin
      meta_ff.band <= meta_i.band;
      meta_ff.div  <= meta_i.div;
      meta_ff.fb   <= meta_i.fb;
      meta_ff.fen  <= meta_i.fen;
      frac_ff      <= frac_in;
      done_ff      <= done_in;
      sdm_ff       <= {sdm_i[SDM_W-2:0], hit};
   end

   assign meta_o = meta_ff;
   assign frac_o = frac_ff;
   assign done_o = done_ff;
   assign sdm_o  = sdm_ff;

endmodule

// ===== rtl/tuner_pll_tuning_word_calc_core.sv =====
// ----------------------------------------------------------------------------
// Tuner PLL tuning-word calculator
// Turns an RF frequency into band, divider, feedback and sigma-delta words.
// ----------------------------------------------------------------------------
// An item is accepted at each rising edge with start high and busy low; busy
// is high while reset is applied and until the first edge with reset low, and
// from then on an item may be issued every cycle.
// Each result appears on the rsp_ ports for one cycle, marked by rsp_valid,
// and results come in order of acceptance. Each item passes through the
// 39-stage restoring division of the VCO frequency by the crystal frequency,
// the 16 stages of the fraction search and five further register stages
// around them. The block takes one item per cycle while busy is low. The
// receiver cannot stall the block, so no back-pressure exists. Registers are
// written through csr_we, csr_index and csr_wdata; the user must write them
// only while no item is in flight, which the block does not enforce.
// Synchronous reset empties the pipeline and restores the crystal to 32 MHz
// and the IF offset to 5 MHz.
// ----------------------------------------------------------------------------
module tuner_pll_tuning_word_calc_core
   import tpll_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [31:0]          req_rf_freq_hz,
   input  logic                 csr_we,
   input  logic                 csr_index,
   input  logic [31:0]          csr_wdata,
   output logic                 rsp_valid,
   output logic [4:0]           rsp_band_index,
   output logic                 rsp_open_drain,
   output logic [7:0]           rsp_rf_mux_poly,
   output logic [7:0]           rsp_tf_band,
   output logic [2:0]           rsp_out_divider,
   output logic [7:0]           rsp_feedback_word,
   output logic [15:0]          rsp_sdm_word,
   output logic                 rsp_frac_enable
);

   logic [XTAL_W-1:0]    xtal_ff;
   logic [WORD_W-1:0]    if_off_ff;
   logic                 busy_ff;
   logic                 s1_valid_ff;
   logic [WORD_W-1:0]    s1_lo_ff;
   logic [MHZ_W-1:0]     s1_mhz_ff;
   logic [44:0]          mhz_prod;

   div_meta_type         dmeta [DIV_STAGES+1];
   logic [XTAL_W-1:0]    drem  [DIV_STAGES+1];
   logic [DVD_W-1:0]     ddvd  [DIV_STAGES+1];
   logic [DVD_W-1:0]     dquo  [DIV_STAGES+1];

   logic                 fr_valid_ff;
   logic [4:0]           fr_band_ff;
   logic [2:0]           fr_div_ff;
   logic [7:0]           fr_nint_ff;
   logic [WORD_W-1:0]    fr_frac_ff;
   logic [7:0]           nint;
   logic [33:0]          nprod;

   sdm_meta_type         smeta [SDM_W+1];
   logic [WORD_W-1:0]    sfrac [SDM_W+1];
   logic                 sdone [SDM_W+1];
   logic [SDM_W-1:0]     ssdm  [SDM_W+1];
   sdm_meta_type         sm_in;
   logic [7:0]           nb;

   logic                 out_valid_ff;
   logic [4:0]           out_band_ff;
   logic                 out_od_ff;
   logic [7:0]           out_mux_ff, out_cap_ff, out_fb_ff;
   logic [2:0]           out_div_ff;
   logic [SDM_W-1:0]     out_sdm_ff;
   logic                 out_fen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         xtal_ff   <= 26'd32000000;
         if_off_ff <= 32'd5000000;
         busy_ff   <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
         if (csr_we) begin
            case (csr_index)
               CSR_XTAL:      xtal_ff   <= csr_wdata[XTAL_W-1:0];
               CSR_IF_OFFSET: if_off_ff <= csr_wdata;
               default:       if_off_ff <= if_off_ff;
            endcase
         end
      end
   end

   assign busy     = busy_ff;
   assign mhz_prod = {13'd0, req_rf_freq_hz} * {32'd0, MHZ_MUL};

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= start && !busy_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_lo_ff  <= req_rf_freq_hz + if_off_ff;
      s1_mhz_ff <= mhz_prod[44:32];
   end

   tpll_front u_front (
      .clock    (clock),
      .reset    (reset),
      .valid    (s1_valid_ff),
      .lo       (s1_lo_ff),
      .mhz      (s1_mhz_ff),
      .xtal     (xtal_ff),
      .meta     (dmeta[0]),
      .dividend (ddvd[0])
   );

   assign drem[0] = '0;
   assign dquo[0] = '0;

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
      tpll_div_stage u_stage (
         .clock   (clock),
         .reset   (reset),
         .divisor (xtal_ff),
         .meta_i  (dmeta[k]),
         .rem_i   (drem[k]),
         .dvd_i   (ddvd[k]),
         .quo_i   (dquo[k]),
         .meta_o  (dmeta[k+1]),
         .rem_o   (drem[k+1]),
         .dvd_o   (ddvd[k+1]),
         .quo_o   (dquo[k+1])
      );
   end

   assign nint  = (xtal_ff == '0) ? 8'd0 : dquo[DIV_STAGES][7:0];
   assign nprod = {8'd0, xtal_ff} * {26'd0, nint};

   always_ff @(posedge clock) begin
      if (reset) begin
         fr_valid_ff <= 1'b0;
      end else begin
         fr_valid_ff <= dmeta[DIV_STAGES].valid;
      end
   end

   always_ff @(posedge clock) begin
      fr_band_ff <= dmeta[DIV_STAGES].band;
      fr_div_ff  <= dmeta[DIV_STAGES].div;
      fr_nint_ff <= nint;
      fr_frac_ff <= dmeta[DIV_STAGES].vco[WORD_W-1:0] - nprod[WORD_W-1:0];
   end

   always_comb begin
      nb          = fr_nint_ff - NINT_BIAS;
      sm_in.valid = fr_valid_ff;
      sm_in.band  = fr_band_ff;
      sm_in.div   = fr_div_ff;
      sm_in.fb    = {nb[1:0], nb[7:2]};
      sm_in.fen   = fr_frac_ff != '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         smeta[0].valid <= 1'b0;
      end else begin
         smeta[0].valid <= sm_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      smeta[0].band <= sm_in.band;
      smeta[0].div  <= sm_in.div;
      smeta[0].fb   <= sm_in.fb;
      smeta[0].fen  <= sm_in.fen;
      sfrac[0]      <= fr_frac_ff + {23'd0, xtal_ff[XTAL_W-1:17]};
      sdone[0]      <= !sm_in.fen;
      ssdm[0]       <= '0;
   end

   for (genvar n = 0; n < SDM_W; n++) begin : g_sdm
      tpll_sdm_stage u_stage (
         .clock  (clock),
         .reset  (reset),
         .step   (xtal_ff[XTAL_W-1:1] >> n),
         .meta_i (smeta[n]),
         .frac_i (sfrac[n]),
         .done_i (sdone[n]),
         .sdm_i  (ssdm[n]),
         .meta_o (smeta[n+1]),
         .frac_o (sfrac[n+1]),
         .done_o (sdone[n+1]),
         .sdm_o  (ssdm[n+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= smeta[SDM_W].valid;
      end
   end

   always_ff @(posedge clock) begin
      out_band_ff <= smeta[SDM_W].band;
      out_od_ff   <= BAND_OD[smeta[SDM_W].band];
      out_mux_ff  <= BAND_MUX[smeta[SDM_W].band];
      out_cap_ff  <= BAND_CAP[smeta[SDM_W].band];
      out_div_ff  <= smeta[SDM_W].div;
      out_fb_ff   <= smeta[SDM_W].fb;
      out_sdm_ff  <= ssdm[SDM_W];
      out_fen_ff  <= smeta[SDM_W].fen;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_band_index    = out_band_ff;
   assign rsp_open_drain    = out_od_ff;
   assign rsp_rf_mux_poly   = out_mux_ff;
   assign rsp_tf_band       = out_cap_ff;
   assign rsp_out_divider   = out_div_ff;
   assign rsp_feedback_word = out_fb_ff;
   assign rsp_sdm_word      = out_sdm_ff;
   assign rsp_frac_enable   = out_fen_ff;

   // A result without a fractional remainder carries no sigma-delta bits.
   a_sdm_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_frac_enable |-> rsp_sdm_word == '0)
      else $error("sigma-delta word set without a fractional remainder");

   a_ranges : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_out_divider <= DIV_NONE && rsp_band_index <= 5'd20)
      else $error("divider or band out of range");

   a_reset_flush : assert property (@(posedge clock)
      reset |=> !rsp_valid && busy)
      else $error("pipeline not flushed by reset");

endmodule
